@@ src/tcip_pkg.sv @@
// Package for the terminal color index to pixel converter.
// It holds the pixel format codes, the command codes, the index ranges, the palette and the request word type.
// No dependencies.
`default_nettype none

package tcip_pkg;

   // Pixel format codes held in the format register.
   typedef enum logic [1:0] {
      FMT_8BPP  = 2'd0,
      FMT_555   = 2'd1,
      FMT_565   = 2'd2,
      FMT_24BPP = 2'd3
   } pixel_format_type;

   // Meaning of the command bit of a request word.
   localparam logic CMD_INDEX = 1'b0;
   localparam logic CMD_RGB   = 1'b1;

   // Index ranges and scale factors of the 256-color map.
   localparam logic [7:0] CUBE_BASE   = 8'd16;
   localparam logic [7:0] GREY_BASE   = 8'd232;
   localparam logic [7:0] CUBE_STEP   = 8'd51;
   localparam logic [7:0] GREY_STEP   = 8'd10;
   localparam logic [7:0] GREY_OFFSET = 8'd8;

   // Fixed palette of the first sixteen indices.
   localparam logic [23:0] BASE_COLORS [16] = '{
      24'h282828, 24'hea6962, 24'ha9b665, 24'hd8a657,
      24'h7daea3, 24'hd3869b, 24'h89b482, 24'hd6d6d6,
      24'h3c3836, 24'hea6962, 24'ha9b665, 24'hd8a657,
      24'h7daea3, 24'hd3869b, 24'h89b482, 24'hd4be98
   };

   // One request word as held in the input register.
   typedef struct packed {
      logic        command;
      logic [23:0] color_value;
   } req_word_type;

endpackage

`default_nettype wire

@@ src/tcip_index_rgb.sv @@
// Maps a 256-color terminal index to a 24-bit RGB color.
// Depends on tcip_pkg for the palette and the index ranges.
`default_nettype none

module tcip_index_rgb (
   input  wire logic [7:0]  color_index,
   output logic      [23:0] rgb
);
   import tcip_pkg::*;

   logic [7:0] cube_v;
   logic [2:0] r_level;
   logic [5:0] rem36;
   logic [2:0] g_level;
   logic [2:0] b_level;
   logic [7:0] r_chan;
   logic [7:0] g_chan;
   logic [7:0] b_chan;
   logic [4:0] grey_step;
   logic [7:0] grey_chan;

   // Offset into the 6x6x6 cube.
   assign cube_v = color_index - CUBE_BASE;

   // Red level is the cube offset over 36, found by threshold compares.
   always_comb begin
      r_level = 3'd0;
      for (int k = 1; k < 6; k++) begin
         if (cube_v >= 8'(36 * k)) begin
            r_level = 3'(k);
         end
      end
   end

   assign rem36 = 6'(cube_v - 8'({5'b0, r_level} * 8'd36));

   // Green level is the remainder over 6; blue is what is left.
   always_comb begin
      g_level = 3'd0;
      for (int k = 1; k < 6; k++) begin
         if (rem36 >= 6'(6 * k)) begin
            g_level = 3'(k);
         end
      end
   end

   assign b_level = 3'(rem36 - 6'({3'b0, g_level} * 6'd6));

   // Scale each level to the full channel range.
   assign r_chan = 8'({5'b0, r_level} * CUBE_STEP);
   assign g_chan = 8'({5'b0, g_level} * CUBE_STEP);
   assign b_chan = 8'({5'b0, b_level} * CUBE_STEP);

   // Grey ramp for the top indices.
   assign grey_step = 5'(color_index - GREY_BASE);
   assign grey_chan = 8'({3'b0, grey_step} * GREY_STEP + GREY_OFFSET);

   // Pick the range the index falls in.
   always_comb begin
      priority if (color_index >= GREY_BASE) begin
         rgb = {grey_chan, grey_chan, grey_chan};
      end else if (color_index < CUBE_BASE) begin
         rgb = BASE_COLORS[color_index[3:0]];
      end else begin
         rgb = {r_chan, g_chan, b_chan};
      end
   end

endmodule

`default_nettype wire

@@ src/tcip_pack.sv @@
// Packs a 24-bit RGB color into the configured pixel format.
// Depends on tcip_pkg for the pixel format codes.
`default_nettype none

module tcip_pack (
   input  wire logic [23:0]               rgb,
   input  wire tcip_pkg::pixel_format_type pixel_format,
   output logic      [23:0]               pixel_color,
   output logic                           color_valid
);
   import tcip_pkg::*;

   // Each channel keeps its top bits; 8 bpp gives no color.
   always_comb begin
      unique case (pixel_format)
         FMT_8BPP: begin
            pixel_color = 24'd0;
            color_valid = 1'b0;
         end
         FMT_555: begin
            pixel_color = {9'd0, rgb[23:19], rgb[15:11], rgb[7:3]};
            color_valid = 1'b1;
         end
         FMT_565: begin
            pixel_color = {8'd0, rgb[23:19], rgb[15:10], rgb[7:3]};
            color_valid = 1'b1;
         end
         default: begin
            pixel_color = rgb;
            color_valid = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ src/terminal_color_index_to_pixel_core.sv @@
// Converts terminal color words to pixels: a 256-color index or a direct RGB
// value goes in, a color packed as 5-5-5, 5-6-5 or 24-bit RGB comes out, with
// color_valid low at 8 bpp. A word can be taken every cycle while the result
// port is not stalled. It is first held in the input register, and its result
// is offered on the result port from the result register, with the lookup and
// packing between them. The format register may be written only while no word
// is in flight.
// Depends on tcip_pkg, tcip_index_rgb and tcip_pack.
`default_nettype none

module terminal_color_index_to_pixel_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [23:0] req_color_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [23:0] rsp_pixel_color,
   output logic             rsp_color_valid
);
   import tcip_pkg::*;

   pixel_format_type fmt_ff;
   logic             s1_valid_ff;
   logic             s1_valid_in;
   req_word_type     s1_word_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [23:0]      rsp_pixel_color_ff;
   logic             rsp_color_valid_ff;
   logic             rsp_load;
   logic             req_take;
   logic [23:0]      index_rgb;
   logic [23:0]      rgb;
   logic [23:0]      pixel_color;
   logic             color_valid;

   // Format register.
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_24BPP;
      end else if (csr_wr_en) begin
         fmt_ff <= pixel_format_type'(csr_wr_data);
      end
   end

   // Handshake: the result register loads when empty or being drained.
   assign rsp_load  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || rsp_load;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !rsp_load);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff.command     <= req_command;
         s1_word_ff.color_value <= req_color_value;
      end
   end

   // Color lookup and packing.
   tcip_index_rgb u_index_rgb (
      .color_index (s1_word_ff.color_value[7:0]),
      .rgb         (index_rgb)
   );

   assign rgb = (s1_word_ff.command == CMD_RGB) ? s1_word_ff.color_value : index_rgb;

   tcip_pack u_pack (
      .rgb          (rgb),
      .pixel_format (fmt_ff),
      .pixel_color  (pixel_color),
      .color_valid  (color_valid)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pixel_color_ff <= pixel_color;
         rsp_color_valid_ff <= color_valid;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_pixel_color_ff;
   assign rsp_color_valid = rsp_color_valid_ff;

endmodule

`default_nettype wire
